>>> design/dfr_pkg.sv
// Package of the sync/length/checksum deframer: item and result types,
// frame constants and engine states. No dependencies.
package dfr_pkg;

    localparam int HEADER_LEN    = 10;
    localparam int FRAME_MAX     = 64;
    localparam int CHECK_POS     = 9;
    localparam int TIMEOUT_RESET = 100;
    localparam int QUEUE_DEPTH   = 4;

    localparam logic [7:0] SYNC_B0 = 8'h49;
    localparam logic [7:0] SYNC_B1 = 8'h34;
    localparam logic [7:0] SYNC_B2 = 8'h53;
    localparam logic [7:0] SYNC_B3 = 8'h30;

    localparam logic CFG_TIMEOUT   = 1'b0;
    localparam logic CFG_DIRECTION = 1'b1;

    typedef struct packed {
        logic       is_tick;
        logic [7:0] data;
    } item_t;

    typedef struct packed {
        logic [7:0] command;
        logic [7:0] sub_command;
        logic [5:0] payload_length;
        logic [7:0] payload_byte;
        logic [5:0] byte_index;
        logic       empty_payload;
        logic       last;
    } result_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SYNC,
        ST_SYNC_CMP,
        ST_HDR_RD,
        ST_HDR_ACC,
        ST_LEN_CHK,
        ST_SUM_CHK,
        ST_EMPTY,
        ST_EMIT_RD,
        ST_EMIT_WR,
        ST_DROP
    } state_t;

    function automatic logic [7:0] sync_byte(input logic [1:0] k);
        logic [7:0] b;
        case (k)
            2'd0:    b = SYNC_B0;
            2'd1:    b = SYNC_B1;
            2'd2:    b = SYNC_B2;
            default: b = SYNC_B3;
        endcase
        return b;
    endfunction

endpackage

>>> design/dfr_in_queue.sv
// Input queue of the deframer: holds received bytes and ticks, tagged by kind.
// Depends on dfr_pkg.
module dfr_in_queue (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    input  logic           req_type,
    input  logic [7:0]     rx_byte,
    output logic           full,
    input  logic           pop,
    output logic           empty,
    output dfr_pkg::item_t item
);
    import dfr_pkg::*;

    item_t      q_mem [QUEUE_DEPTH];
    logic [1:0] wr_ptr_reg, rd_ptr_reg;
    logic [2:0] count_reg;
    logic       do_push, do_pop;

    assign full    = (count_reg == 3'(QUEUE_DEPTH));
    assign empty   = (count_reg == 3'd0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign item    = q_mem[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            q_mem[wr_ptr_reg] <= '{is_tick: req_type, data: rx_byte};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 2'd1;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 2'd1;
            end
            count_reg <= count_reg + 3'(do_push) - 3'(do_pop);
        end
    end

endmodule

>>> design/dfr_out_queue.sv
// Result queue of the deframer: holds finished results until they are taken.
// Depends on dfr_pkg.
module dfr_out_queue (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  dfr_pkg::result_t wdata,
    output logic             full,
    input  logic             pop,
    output logic             empty,
    output dfr_pkg::result_t rdata
);
    import dfr_pkg::*;

    result_t    q_mem [QUEUE_DEPTH];
    logic [1:0] wr_ptr_reg, rd_ptr_reg;
    logic [2:0] count_reg;
    logic       do_push, do_pop;

    assign full    = (count_reg == 3'(QUEUE_DEPTH));
    assign empty   = (count_reg == 3'd0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign rdata   = q_mem[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            q_mem[wr_ptr_reg] <= wdata;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 2'd1;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 2'd1;
            end
            count_reg <= count_reg + 3'(do_push) - 3'(do_pop);
        end
    end

endmodule

>>> design/dfr_engine.sv
// Frame engine of the deframer: circular assembly buffer, sync search, length
// and checksum checks, and payload emission. Depends on dfr_pkg.
module dfr_engine (
    input  logic             clk,
    input  logic             rst_n,
    input  logic [15:0]      timeout_ticks,
    input  logic [7:0]       accept_direction,
    input  logic             in_empty,
    input  dfr_pkg::item_t   in_item,
    output logic             in_pop,
    input  logic             out_full,
    output logic             res_push,
    output dfr_pkg::result_t res
);
    import dfr_pkg::*;

    logic [7:0]  buf_mem [FRAME_MAX];
    logic [7:0]  rdata_reg;

    state_t      state_reg, state_next;
    logic [5:0]  head_reg, head_next;
    logic [6:0]  fill_reg, fill_next;
    logic [15:0] idle_reg, idle_next;
    logic [6:0]  k_reg, k_next;
    logic [7:0]  sum_reg, sum_next;
    logic [7:0]  len_lo_reg, len_lo_next, len_hi_reg, len_hi_next;
    logic [7:0]  dir_reg, dir_next, cmd_reg, cmd_next;
    logic [7:0]  sub_reg, sub_next, chk_reg, chk_next;

    logic        wr_en, rd_en;
    logic [5:0]  wr_addr, rd_addr;
    logic [15:0] flen;
    logic [6:0]  flen7;
    logic [5:0]  plen;
    logic [15:0] idle_sat;
    logic [6:0]  k_inc;

    assign flen     = {len_hi_reg, len_lo_reg};
    assign flen7    = flen[6:0];
    assign plen     = 6'(flen7 - 7'(HEADER_LEN));
    assign idle_sat = (idle_reg == 16'hFFFF) ? idle_reg : idle_reg + 16'd1;
    assign k_inc    = k_reg + 7'd1;
    assign wr_addr  = head_reg + fill_reg[5:0];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            buf_mem[wr_addr] <= in_item.data;
        end
        if (rd_en)
        begin
            rdata_reg <= buf_mem[rd_addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            head_reg  <= '0;
            fill_reg  <= '0;
            idle_reg  <= '0;
            k_reg     <= '0;
        end
        else
        begin
            state_reg <= state_next;
            head_reg  <= head_next;
            fill_reg  <= fill_next;
            idle_reg  <= idle_next;
            k_reg     <= k_next;
        end
    end

    always_ff @(posedge clk)
    begin
        sum_reg    <= sum_next;
        len_lo_reg <= len_lo_next;
        len_hi_reg <= len_hi_next;
        dir_reg    <= dir_next;
        cmd_reg    <= cmd_next;
        sub_reg    <= sub_next;
        chk_reg    <= chk_next;
    end

    always_comb
    begin
        state_next  = state_reg;
        head_next   = head_reg;
        fill_next   = fill_reg;
        idle_next   = idle_reg;
        k_next      = k_reg;
        sum_next    = sum_reg;
        len_lo_next = len_lo_reg;
        len_hi_next = len_hi_reg;
        dir_next    = dir_reg;
        cmd_next    = cmd_reg;
        sub_next    = sub_reg;
        chk_next    = chk_reg;
        wr_en       = 1'b0;
        rd_en       = 1'b0;
        rd_addr     = head_reg + k_reg[5:0];
        in_pop      = 1'b0;
        res_push    = 1'b0;
        res         = '{command: cmd_reg, sub_command: sub_reg, payload_length: plen,
                        payload_byte: rdata_reg, byte_index: k_reg[5:0],
                        empty_payload: 1'b0, last: (k_inc == 7'(plen))};

        case (state_reg)
            ST_IDLE:
            begin
                if (!in_empty)
                begin
                    in_pop = 1'b1;
                    if (in_item.is_tick)
                    begin
                        if (fill_reg != 7'd0 && idle_sat >= timeout_ticks)
                        begin
                            fill_next = '0;
                            idle_next = '0;
                        end
                        else
                        begin
                            idle_next = idle_sat;
                        end
                    end
                    else
                    begin
                        if (fill_reg < 7'(FRAME_MAX))
                        begin
                            wr_en     = 1'b1;
                            fill_next = fill_reg + 7'd1;
                        end
                        idle_next  = '0;
                        k_next     = '0;
                        state_next = ST_SYNC;
                    end
                end
            end
            ST_SYNC:
            begin
                if (fill_reg == 7'd0)
                begin
                    state_next = ST_IDLE;
                end
                else if (k_reg == 7'd4 || k_reg == fill_reg)
                begin
                    k_next   = '0;
                    sum_next = '0;
                    state_next = (fill_reg < 7'(HEADER_LEN)) ? ST_IDLE : ST_HDR_RD;
                end
                else
                begin
                    rd_en      = 1'b1;
                    state_next = ST_SYNC_CMP;
                end
            end
            ST_SYNC_CMP:
            begin
                if (rdata_reg != sync_byte(k_reg[1:0]))
                begin
                    head_next = head_reg + 6'd1;
                    fill_next = fill_reg - 7'd1;
                    k_next    = '0;
                end
                else
                begin
                    k_next = k_inc;
                end
                state_next = ST_SYNC;
            end
            ST_HDR_RD:
            begin
                rd_en      = 1'b1;
                state_next = ST_HDR_ACC;
            end
            ST_HDR_ACC:
            begin
                if (k_reg != 7'(CHECK_POS))
                begin
                    sum_next = sum_reg + rdata_reg;
                end
                case (k_reg)
                    7'd4:    len_lo_next = rdata_reg;
                    7'd5:    len_hi_next = rdata_reg;
                    7'd6:    dir_next    = rdata_reg;
                    7'd7:    cmd_next    = rdata_reg;
                    7'd8:    sub_next    = rdata_reg;
                    7'd9:    chk_next    = rdata_reg;
                    default: ;
                endcase
                k_next = k_inc;
                if (k_inc == 7'(HEADER_LEN))
                begin
                    state_next = ST_LEN_CHK;
                end
                else if (k_inc > 7'(HEADER_LEN) && k_inc == flen7)
                begin
                    state_next = ST_SUM_CHK;
                end
                else
                begin
                    state_next = ST_HDR_RD;
                end
            end
            ST_LEN_CHK:
            begin
                if (flen < 16'(HEADER_LEN) || flen > 16'(FRAME_MAX))
                begin
                    head_next  = head_reg + 6'd1;
                    fill_next  = fill_reg - 7'd1;
                    k_next     = '0;
                    state_next = ST_SYNC;
                end
                else if (fill_reg < flen7)
                begin
                    state_next = ST_IDLE;
                end
                else if (flen7 == 7'(HEADER_LEN))
                begin
                    state_next = ST_SUM_CHK;
                end
                else
                begin
                    state_next = ST_HDR_RD;
                end
            end
            ST_SUM_CHK:
            begin
                k_next = '0;
                if (sum_reg != chk_reg)
                begin
                    head_next  = head_reg + 6'd1;
                    fill_next  = fill_reg - 7'd1;
                    state_next = ST_SYNC;
                end
                else if (dir_reg == accept_direction)
                begin
                    state_next = (flen7 == 7'(HEADER_LEN)) ? ST_EMPTY : ST_EMIT_RD;
                end
                else
                begin
                    state_next = ST_DROP;
                end
            end
            ST_EMPTY:
            begin
                res = '{command: cmd_reg, sub_command: sub_reg, payload_length: 6'd0,
                        payload_byte: 8'd0, byte_index: 6'd0,
                        empty_payload: 1'b1, last: 1'b1};
                if (!out_full)
                begin
                    res_push   = 1'b1;
                    state_next = ST_DROP;
                end
            end
            ST_EMIT_RD:
            begin
                rd_en      = 1'b1;
                rd_addr    = head_reg + 6'(HEADER_LEN) + k_reg[5:0];
                state_next = ST_EMIT_WR;
            end
            ST_EMIT_WR:
            begin
                if (!out_full)
                begin
                    res_push   = 1'b1;
                    k_next     = k_inc;
                    state_next = (k_inc == 7'(plen)) ? ST_DROP : ST_EMIT_RD;
                end
            end
            ST_DROP:
            begin
                head_next  = head_reg + flen7[5:0];
                fill_next  = fill_reg - flen7;
                k_next     = '0;
                state_next = ST_SYNC;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg <= 7'(FRAME_MAX))
        else $error("fill count above buffer depth");

    a_pop_idle: assert property (@(posedge clk) disable iff (!rst_n)
        in_pop |-> state_reg == ST_IDLE)
        else $error("item taken while a frame is in work");

    a_push_room: assert property (@(posedge clk) disable iff (!rst_n)
        res_push |-> !out_full)
        else $error("result pushed into a full queue");

    a_drop_len: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_DROP |=> fill_reg == $past(fill_reg) - $past(flen7))
        else $error("frame drop removed the wrong byte count");

endmodule

>>> design/sync_length_checksum_deframer_core.sv
// Top level of the deframer: config registers, input queue, frame engine, result queue.
// Depends on dfr_pkg and the dfr modules.
// A tick advances the idle count and may flush a stale partial frame; each byte restarts
// the sync search, so the sync word and header are re-read from the buffer. A checked frame
// of the accepted direction yields one result per payload byte, or a single empty_payload
// result; pushes wait while the result queue is full. A failed check drops one byte and rescans.
module sync_length_checksum_deframer_core (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    output logic        full,
    input  logic        req_type,
    input  logic [7:0]  rx_byte,
    output logic        empty,
    input  logic        pop,
    output logic [7:0]  command,
    output logic [7:0]  sub_command,
    output logic [5:0]  payload_length,
    output logic [7:0]  payload_byte,
    output logic [5:0]  byte_index,
    output logic        empty_payload,
    output logic        last,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic        cfg_index,
    input  logic [15:0] cfg_data
);
    import dfr_pkg::*;

    logic [15:0] timeout_reg;
    logic [7:0]  direction_reg;
    item_t       in_item;
    logic        in_empty, in_pop;
    logic        out_full, res_push;
    result_t     res, out_res;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            timeout_reg   <= 16'(TIMEOUT_RESET);
            direction_reg <= '0;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                CFG_TIMEOUT:   timeout_reg   <= cfg_data;
                CFG_DIRECTION: direction_reg <= cfg_data[7:0];
                default:       ;
            endcase
        end
    end

    dfr_in_queue u_in_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .req_type (req_type),
        .rx_byte  (rx_byte),
        .full     (full),
        .pop      (in_pop),
        .empty    (in_empty),
        .item     (in_item)
    );

    dfr_engine u_engine (
        .clk              (clk),
        .rst_n            (rst_n),
        .timeout_ticks    (timeout_reg),
        .accept_direction (direction_reg),
        .in_empty         (in_empty),
        .in_item          (in_item),
        .in_pop           (in_pop),
        .out_full         (out_full),
        .res_push         (res_push),
        .res              (res)
    );

    dfr_out_queue u_out_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (res_push),
        .wdata (res),
        .full  (out_full),
        .pop   (pop),
        .empty (empty),
        .rdata (out_res)
    );

    assign command        = out_res.command;
    assign sub_command    = out_res.sub_command;
    assign payload_length = out_res.payload_length;
    assign payload_byte   = out_res.payload_byte;
    assign byte_index     = out_res.byte_index;
    assign empty_payload  = out_res.empty_payload;
    assign last           = out_res.last;

endmodule
